[hdl/pzs_pkg.sv]
// Package for the pitch zone servo controller: fixed codes, constants and
// the control/status types shared by the top level and the serial MAC.
// No dependencies.
package pzs_pkg;

    localparam logic [7:0] HDR_SYNC   = 8'h55;
    localparam logic [7:0] KIND_ANGLE = 8'h53;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_INNER_GAIN  = 2'd0;
    localparam logic [1:0] REG_OUTER_GAIN  = 2'd1;
    localparam logic [1:0] REG_RATE_GAIN   = 2'd2;
    localparam logic [1:0] REG_TRIM_OFFSET = 2'd3;

    localparam logic signed [15:0] INNER_GAIN_RST  = 16'sd102;
    localparam logic signed [15:0] OUTER_GAIN_RST  = 16'sd1024;
    localparam logic signed [15:0] RATE_GAIN_RST   = 16'sd0;
    localparam logic signed [15:0] TRIM_OFFSET_RST = 16'sd1280;

    // Zone codes
    localparam logic [1:0] ZONE_INNER = 2'd0;
    localparam logic [1:0] ZONE_UP    = 2'd1;
    localparam logic [1:0] ZONE_DOWN  = 2'd2;
    localparam logic [1:0] ZONE_HELD  = 2'd3;

    // Servo scale 8.6469 and base 1503.2, both in Q16
    localparam logic [19:0] SERVO_GAIN = 20'd566683;
    localparam logic [26:0] SERVO_BASE = 27'd98513715;

    // Multiplier digits: 16-bit signed gains and the 20-bit unsigned servo
    // scale both fit a 21-bit two's complement multiplier.
    localparam int MUL_W = 21;
    localparam int CNT_W = $clog2(MUL_W);

    typedef struct packed {
        logic busy;
        logic done;
    } pzs_mac_sts_t;

endpackage

[hdl/pzs_mac.sv]
// Bit-serial multiply-accumulate: acc = init + opa*mula + opb*mulb,
// one multiplier bit per cycle, MSB weighted negative.
// Depends on pzs_pkg.
module pzs_mac
    import pzs_pkg::*;
#(
    parameter int ACC_W = 48
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load,
    input  logic signed [ACC_W-1:0] init_acc,
    input  logic signed [ACC_W-1:0] opa,
    input  logic signed [ACC_W-1:0] opb,
    input  logic [MUL_W-1:0]        mula,
    input  logic [MUL_W-1:0]        mulb,
    output logic signed [ACC_W-1:0] acc,
    output pzs_mac_sts_t            sts
);

    logic                    busy_reg, busy_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] opa_reg, opa_next;
    logic signed [ACC_W-1:0] opb_reg, opb_next;
    logic [MUL_W-1:0]        mula_reg, mula_next;
    logic [MUL_W-1:0]        mulb_reg, mulb_next;
    logic                    last;
    logic signed [ACC_W-1:0] ppa, ppb;

    assign last = (cnt_reg == CNT_W'(MUL_W - 1));
    assign ppa  = mula_reg[0] ? opa_reg : '0;
    assign ppb  = mulb_reg[0] ? opb_reg : '0;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        opa_next  = opa_reg;
        opb_next  = opb_reg;
        mula_next = mula_reg;
        mulb_next = mulb_reg;
        if (load) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = init_acc;
            opa_next  = opa;
            opb_next  = opb;
            mula_next = mula;
            mulb_next = mulb;
        end else if (busy_reg) begin
            acc_next  = last ? (acc_reg - ppa - ppb) : (acc_reg + ppa + ppb);
            opa_next  = opa_reg <<< 1;
            opb_next  = opb_reg <<< 1;
            mula_next = mula_reg >> 1;
            mulb_next = mulb_reg >> 1;
            cnt_next  = cnt_reg + CNT_W'(1);
            if (last) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        opa_reg  <= opa_next;
        opb_reg  <= opb_next;
        mula_reg <= mula_next;
        mulb_reg <= mulb_next;
    end

    assign acc      = acc_reg;
    assign sts.busy = busy_reg;
    assign sts.done = busy_reg & last;

endmodule

[hdl/pitch_zone_servo_controller_top.sv]
// Pitch zone servo controller top level: packet decode, head angle, trim,
// zone rule and servo scaling around one shared bit-serial MAC.
// Depends on pzs_pkg and pzs_mac.
//
//  channel  direction  handshake              contents
//  s_       in         s_valid / s_ready      frame_header, packet_kind, pitch_raw
//  m_       out        m_valid / m_ready      servo_compare, drive_angle, zone, trim_latched
//  cfg_     in         cfg_wr_en              cfg_index, cfg_wdata
//
// A transaction with header 0x55 runs decode, the drive MAC pass (skipped in
// the held zone) and the servo MAC pass before s_ready rises again.
// A transaction with any other header is dropped in its accept cycle.
// Synchronous active-low reset clears state and loads default gains.
// The result sits in an output register; a stalled m_ready only holds the
// block once the next result is finished.
module pitch_zone_servo_controller_top
    import pzs_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_frame_header,
    input  logic [7:0]         s_packet_kind,
    input  logic signed [15:0] s_pitch_raw,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_servo_compare,
    output logic signed [18:0] m_drive_angle,
    output logic [1:0]         m_zone,
    output logic               m_trim_latched,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata
);

    localparam int F         = ANGLE_FRAC_BITS;
    localparam int TRIM_W    = (F + 8 > 16) ? F + 8 : 16;
    localparam int X_W       = ((TRIM_W > 19) ? TRIM_W : 19) + 1;
    localparam int TRIM_SHL  = (F >= 8) ? F - 8 : 0;
    localparam int TRIM_SHR  = (F >= 8) ? 0 : 8 - F;
    localparam int ACC_A     = (20 + X_W > 28 + F) ? 20 + X_W : 28 + F;
    localparam int ACC_W     = ((ACC_A > 39) ? ACC_A : 39) + 1;

    localparam logic signed [19:0] LIM5  = 20'(5 << F);
    localparam logic signed [19:0] LIM10 = 20'(10 << F);
    localparam logic signed [19:0] LIM25 = 20'(25 << F);
    localparam logic signed [21:0] LIM2  = 22'(2 << F);
    localparam logic signed [24:0] PIT_HI = 25'sd524287;
    localparam logic signed [24:0] PIT_LO = -25'sd524288;
    localparam logic signed [20:0] HEAD_HI = 21'sd524287;
    localparam logic signed [20:0] HEAD_LO = -21'sd524288;
    localparam logic signed [ACC_W-1:0] DRV_HI = ACC_W'(262143);
    localparam logic signed [ACC_W-1:0] DRV_LO = -DRV_HI - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SRV_HI = ACC_W'(65535);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_MUL   = 11'b000_0000_0010,
        ST_PITCH = 11'b000_0000_0100,
        ST_HEAD  = 11'b000_0000_1000,
        ST_RATE  = 11'b000_0001_0000,
        ST_LOAD  = 11'b000_0010_0000,
        ST_MAC   = 11'b000_0100_0000,
        ST_DRIVE = 11'b000_1000_0000,
        ST_SLOAD = 11'b001_0000_0000,
        ST_SMAC  = 11'b010_0000_0000,
        ST_OUT   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic signed [15:0] inner_gain_reg, inner_gain_next;
    logic signed [15:0] outer_gain_reg, outer_gain_next;
    logic signed [15:0] rate_gain_reg, rate_gain_next;
    logic signed [15:0] trim_offset_reg, trim_offset_next;

    logic signed [19:0] pitch_reg, pitch_next;
    logic signed [19:0] lvl_trim_reg, lvl_trim_next;
    logic signed [19:0] prev1_reg, prev1_next;
    logic signed [19:0] prev2_reg, prev2_next;
    logic signed [19:0] held_reg, held_next;
    logic               m_valid_reg, m_valid_next;

    logic [7:0]         kind_reg, kind_next;
    logic signed [15:0] raw_reg, raw_next;
    logic signed [23:0] p180_reg, p180_next;
    logic signed [19:0] head_reg, head_next;
    logic signed [21:0] r2_reg, r2_next;
    logic [1:0]         zone_reg, zone_next;
    logic signed [19:0] xsel_reg, xsel_next;
    logic               latched_reg, latched_next;
    logic signed [18:0] drive_reg, drive_next;
    logic [15:0]        m_servo_reg, m_servo_next;
    logic signed [18:0] m_drive_reg, m_drive_next;
    logic [1:0]         m_zone_reg, m_zone_next;
    logic               m_latched_reg, m_latched_next;

    logic                    mac_load;
    logic signed [ACC_W-1:0] mac_init, mac_opa, mac_opb, mac_acc;
    logic [MUL_W-1:0]        mac_mula, mac_mulb;
    pzs_mac_sts_t            mac_sts;

    logic signed [24:0]      pit_rnd;
    logic signed [19:0]      pit_sat;
    logic signed [20:0]      head_sum;
    logic signed [19:0]      head_sat;
    logic signed [ACC_W-1:0] ig_ext, c20;
    logic signed [ACC_W-1:0] drv_rnd;
    logic signed [18:0]      drv_sat;
    logic signed [X_W-1:0]   trim_q, x_val;
    logic signed [ACC_W-1:0] srv_shr;
    logic [15:0]             srv_sat;

    // Pitch: round(raw*180 / 2^(15-F)), saturated
    assign pit_rnd = (25'(p180_reg) + 25'(1 << (14 - F))) >>> (15 - F);
    assign pit_sat = (pit_rnd > PIT_HI) ? 20'sh7FFFF :
                     (pit_rnd < PIT_LO) ? -20'sh80000 : 20'(pit_rnd);

    assign head_sum = 21'(pitch_reg) + 21'(lvl_trim_reg);
    assign head_sat = (head_sum > HEAD_HI) ? 20'sh7FFFF :
                      (head_sum < HEAD_LO) ? -20'sh80000 : 20'(head_sum);

    assign ig_ext = ACC_W'(inner_gain_reg);
    assign c20    = ((ig_ext <<< 4) + (ig_ext <<< 2)) <<< F;

    assign drv_rnd = (mac_acc + ACC_W'(256)) >>> 9;
    assign drv_sat = (drv_rnd > DRV_HI) ? 19'sh3FFFF :
                     (drv_rnd < DRV_LO) ? -19'sh40000 : 19'(drv_rnd);

    assign trim_q = (X_W'(trim_offset_reg) <<< TRIM_SHL) >>> TRIM_SHR;
    assign x_val  = trim_q - X_W'(drive_reg);

    assign srv_shr = mac_acc >>> (16 + F);
    assign srv_sat = (srv_shr < 0) ? 16'h0000 :
                     (srv_shr > SRV_HI) ? 16'hFFFF : srv_shr[15:0];

    always_comb begin
        state_next       = state_reg;
        inner_gain_next  = inner_gain_reg;
        outer_gain_next  = outer_gain_reg;
        rate_gain_next   = rate_gain_reg;
        trim_offset_next = trim_offset_reg;
        pitch_next       = pitch_reg;
        lvl_trim_next    = lvl_trim_reg;
        prev1_next       = prev1_reg;
        prev2_next       = prev2_reg;
        held_next        = held_reg;
        m_valid_next     = m_valid_reg;
        kind_next        = kind_reg;
        raw_next         = raw_reg;
        p180_next        = p180_reg;
        head_next        = head_reg;
        r2_next          = r2_reg;
        zone_next        = zone_reg;
        xsel_next        = xsel_reg;
        latched_next     = latched_reg;
        drive_next       = drive_reg;
        m_servo_next     = m_servo_reg;
        m_drive_next     = m_drive_reg;
        m_zone_next      = m_zone_reg;
        m_latched_next   = m_latched_reg;
        mac_load         = 1'b0;
        mac_init         = '0;
        mac_opa          = '0;
        mac_opb          = '0;
        mac_mula         = '0;
        mac_mulb         = '0;

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_INNER_GAIN:  inner_gain_next  = cfg_wdata;
                REG_OUTER_GAIN:  outer_gain_next  = cfg_wdata;
                REG_RATE_GAIN:   rate_gain_next   = cfg_wdata;
                REG_TRIM_OFFSET: trim_offset_next = cfg_wdata;
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next = s_packet_kind;
                    raw_next  = s_pitch_raw;
                    if (s_frame_header == HDR_SYNC) begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                // 180 = 128 + 32 + 16 + 4
                p180_next  = (24'(raw_reg) <<< 7) + (24'(raw_reg) <<< 5)
                           + (24'(raw_reg) <<< 4) + (24'(raw_reg) <<< 2);
                state_next = ST_PITCH;
            end
            ST_PITCH: begin
                if (kind_reg == KIND_ANGLE) begin
                    pitch_next = pit_sat;
                end
                state_next = ST_HEAD;
            end
            ST_HEAD: begin
                head_next  = head_sat;
                state_next = ST_RATE;
            end
            ST_RATE: begin
                r2_next = (22'(head_reg) <<< 1) - 22'(prev1_reg) - 22'(prev2_reg);
                if (head_reg > -LIM10 && head_reg < LIM10) begin
                    zone_next = ZONE_INNER;
                    xsel_next = head_reg;
                end else if (head_reg > -LIM25 && head_reg < -LIM10) begin
                    zone_next = ZONE_UP;
                    xsel_next = head_reg + LIM10;
                end else if (head_reg > LIM10 && head_reg < LIM25) begin
                    zone_next = ZONE_DOWN;
                    xsel_next = head_reg - LIM10;
                end else begin
                    zone_next = ZONE_HELD;
                    xsel_next = head_reg;
                end
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                latched_next = (head_reg > -LIM5) && (head_reg < LIM5)
                            && (r2_reg > -LIM2) && (r2_reg < LIM2);
                if (latched_next) begin
                    lvl_trim_next = head_reg;
                end
                prev2_next = prev1_reg;
                prev1_next = head_reg;
                mac_opa    = ACC_W'(xsel_reg) <<< 1;
                mac_opb    = -ACC_W'(r2_reg);
                mac_mulb   = MUL_W'(rate_gain_reg);
                case (zone_reg)
                    ZONE_INNER: begin
                        mac_init = '0;
                        mac_mula = MUL_W'(inner_gain_reg);
                    end
                    ZONE_UP: begin
                        mac_init = -c20;
                        mac_mula = MUL_W'(outer_gain_reg);
                    end
                    ZONE_DOWN: begin
                        mac_init = c20;
                        mac_mula = MUL_W'(outer_gain_reg);
                    end
                    default: begin
                        mac_init = '0;
                        mac_mula = '0;
                    end
                endcase
                if (zone_reg == ZONE_HELD) begin
                    state_next = ST_DRIVE;
                end else begin
                    mac_load   = 1'b1;
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                if (mac_sts.done) begin
                    state_next = ST_DRIVE;
                end
            end
            ST_DRIVE: begin
                drive_next = (zone_reg == ZONE_HELD) ? 19'(held_reg) : drv_sat;
                held_next  = 20'(drive_next);
                state_next = ST_SLOAD;
            end
            ST_SLOAD: begin
                mac_load   = 1'b1;
                mac_init   = ACC_W'(SERVO_BASE) <<< F;
                mac_opa    = ACC_W'(x_val);
                mac_mula   = MUL_W'(SERVO_GAIN);
                state_next = ST_SMAC;
            end
            ST_SMAC: begin
                if (mac_sts.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_servo_next   = srv_sat;
                    m_drive_next   = drive_reg;
                    m_zone_next    = zone_reg;
                    m_latched_next = latched_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            inner_gain_reg  <= INNER_GAIN_RST;
            outer_gain_reg  <= OUTER_GAIN_RST;
            rate_gain_reg   <= RATE_GAIN_RST;
            trim_offset_reg <= TRIM_OFFSET_RST;
            pitch_reg       <= '0;
            lvl_trim_reg    <= '0;
            prev1_reg       <= '0;
            prev2_reg       <= '0;
            held_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            inner_gain_reg  <= inner_gain_next;
            outer_gain_reg  <= outer_gain_next;
            rate_gain_reg   <= rate_gain_next;
            trim_offset_reg <= trim_offset_next;
            pitch_reg       <= pitch_next;
            lvl_trim_reg    <= lvl_trim_next;
            prev1_reg       <= prev1_next;
            prev2_reg       <= prev2_next;
            held_reg        <= held_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg      <= kind_next;
        raw_reg       <= raw_next;
        p180_reg      <= p180_next;
        head_reg      <= head_next;
        r2_reg        <= r2_next;
        zone_reg      <= zone_next;
        xsel_reg      <= xsel_next;
        latched_reg   <= latched_next;
        drive_reg     <= drive_next;
        m_servo_reg   <= m_servo_next;
        m_drive_reg   <= m_drive_next;
        m_zone_reg    <= m_zone_next;
        m_latched_reg <= m_latched_next;
    end

    pzs_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (mac_load),
        .init_acc (mac_init),
        .opa      (mac_opa),
        .opb      (mac_opb),
        .mula     (mac_mula),
        .mulb     (mac_mulb),
        .acc      (mac_acc),
        .sts      (mac_sts)
    );

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_servo_compare = m_servo_reg;
    assign m_drive_angle   = m_drive_reg;
    assign m_zone          = m_zone_reg;
    assign m_trim_latched  = m_latched_reg;

`ifndef SYNTHESIS
    a_mac_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_load |-> !mac_sts.busy)
        else $error("MAC loaded while busy");

    a_ready_mac_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !mac_sts.busy)
        else $error("input ready while MAC busy");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output state");

    a_latch_inner: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_trim_latched) |-> (m_zone == ZONE_INNER))
        else $error("trim latched outside inner zone");
`endif

endmodule

[tb/pitch_zone_servo_controller_top_tb.sv]
// Testbench for pitch_zone_servo_controller_top: directed and random sensor packets
// are checked against a cycle-free model of the zone rule, trim latch and servo scaling.
// Depends on pzs_pkg and the DUT sources.
module pitch_zone_servo_controller_top_tb;
    import pzs_pkg::*;

    localparam int     FRAC            = 8;
    localparam longint ONE             = 256;
    localparam longint SERVO_SCALE_Q16 = 566683;
    localparam longint SERVO_BASE_Q16  = 98513715;

    typedef struct packed {
        logic [15:0]        servo;
        logic signed [18:0] drive;
        logic [1:0]         zone;
        logic               latched;
    } servo_result_t;

    logic               aclk            = 1'b0;
    logic               aresetn         = 1'b0;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic [7:0]         s_frame_header  = '0;
    logic [7:0]         s_packet_kind   = '0;
    logic signed [15:0] s_pitch_raw     = '0;
    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic [15:0]        m_servo_compare;
    logic signed [18:0] m_drive_angle;
    logic [1:0]         m_zone;
    logic               m_trim_latched;
    logic               cfg_wr_en       = 1'b0;
    logic [1:0]         cfg_index       = '0;
    logic [15:0]        cfg_wdata       = '0;

    servo_result_t servo_results_q[$];
    servo_result_t want;
    int            mismatch_count = 0;
    int            burst_left     = 0;
    int            rx_stall_left  = 0;
    int            rx_run_left    = 0;

    longint gain_inner, gain_outer, gain_rate, servo_trim;
    longint pitch_q, trim_q, head_prev1, head_prev2, drive_held;

    pitch_zone_servo_controller_top #(
        .ANGLE_FRAC_BITS(FRAC)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_frame_header (s_frame_header),
        .s_packet_kind  (s_packet_kind),
        .s_pitch_raw    (s_pitch_raw),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_servo_compare(m_servo_compare),
        .m_drive_angle  (m_drive_angle),
        .m_zone         (m_zone),
        .m_trim_latched (m_trim_latched),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint sat_to(input longint v, input int w);
        longint hi, lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic longint round_shr(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    task automatic reset_controller_model();
        gain_inner = longint'(INNER_GAIN_RST);
        gain_outer = longint'(OUTER_GAIN_RST);
        gain_rate  = longint'(RATE_GAIN_RST);
        servo_trim = longint'(TRIM_OFFSET_RST);
        pitch_q    = 0;
        trim_q     = 0;
        head_prev1 = 0;
        head_prev2 = 0;
        drive_held = 0;
    endtask

    task automatic advance_controller(input logic [7:0] hdr, input logic [7:0] kind,
                                      input logic signed [15:0] raw);
        longint        head, rate2, acc, drive, servo;
        logic [1:0]    zn;
        logic          latched;
        servo_result_t res;
        if (hdr != HDR_SYNC) return;
        if (kind == KIND_ANGLE)
            pitch_q = sat_to(round_shr(longint'(raw) * 180 * ONE, 15), 20);
        head    = sat_to(pitch_q + trim_q, 20);
        rate2   = 2 * head - head_prev1 - head_prev2;
        latched = 1'b0;
        if (head > -5 * ONE && head < 5 * ONE && rate2 > -2 * ONE && rate2 < 2 * ONE) begin
            trim_q  = head;
            latched = 1'b1;
        end
        acc = 0;
        if (head > -10 * ONE && head < 10 * ONE) begin
            zn  = ZONE_INNER;
            acc = 2 * gain_inner * head - gain_rate * rate2;
        end else if (head > -25 * ONE && head < -10 * ONE) begin
            zn  = ZONE_UP;
            acc = 2 * gain_outer * (head + 10 * ONE) - 20 * ONE * gain_inner
                  - gain_rate * rate2;
        end else if (head > 10 * ONE && head < 25 * ONE) begin
            zn  = ZONE_DOWN;
            acc = 2 * gain_outer * (head - 10 * ONE) + 20 * ONE * gain_inner
                  - gain_rate * rate2;
        end else begin
            zn = ZONE_HELD;
        end
        drive      = (zn == ZONE_HELD) ? drive_held : sat_to(round_shr(acc, 9), 19);
        drive_held = drive;
        servo = (SERVO_SCALE_Q16 * (servo_trim - drive) + SERVO_BASE_Q16 * ONE)
                >>> (16 + FRAC);
        if (servo < 0) servo = 0;
        if (servo > 65535) servo = 65535;
        head_prev2 = head_prev1;
        head_prev1 = head;
        res.servo   = servo[15:0];
        res.drive   = drive[18:0];
        res.zone    = zn;
        res.latched = latched;
        servo_results_q.push_back(res);
    endtask

    task automatic send_packet(input logic [7:0] hdr, input logic [7:0] kind,
                               input logic signed [15:0] raw);
        int idle;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (idle != 0) begin
                s_valid <= 1'b0;
                repeat (idle) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid        <= 1'b1;
        s_frame_header <= hdr;
        s_packet_kind  <= kind;
        s_pitch_raw    <= raw;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        advance_controller(hdr, kind, raw);
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (servo_results_q.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_INNER_GAIN:  gain_inner = longint'($signed(val));
            REG_OUTER_GAIN:  gain_outer = longint'($signed(val));
            REG_RATE_GAIN:   gain_rate  = longint'($signed(val));
            REG_TRIM_OFFSET: servo_trim = longint'($signed(val));
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic program_gains(input logic [15:0] inner, input logic [15:0] outer,
                                 input logic [15:0] rate, input logic [15:0] trim);
        write_reg(REG_INNER_GAIN, inner);
        write_reg(REG_OUTER_GAIN, outer);
        write_reg(REG_RATE_GAIN, rate);
        write_reg(REG_TRIM_OFFSET, trim);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_random_packets(input int count);
        logic [7:0] hdr, kind;
        int         walk, pick;
        int         edges[3];
        edges = '{910, 1820, 4551};
        walk  = 0;
        repeat (count) begin
            hdr  = HDR_SYNC;
            kind = KIND_ANGLE;
            pick = $urandom_range(0, 99);
            if (pick < 7)
                hdr = 8'($urandom);
            else if (pick < 15)
                kind = 8'($urandom);
            case ($urandom_range(0, 5))
                0, 1: begin
                    // slow drift toward level so the trim latch fires
                    walk = walk - walk / 8 + int'($urandom_range(0, 40)) - 20;
                end
                2: walk = int'($urandom_range(0, 9400)) - 4700;
                3: begin
                    walk = edges[$urandom_range(0, 2)] + int'($urandom_range(0, 6)) - 3;
                    if ($urandom_range(0, 1) == 1) walk = -walk;
                end
                4: walk = int'($urandom_range(0, 65535)) - 32768;
                default: walk = int'($urandom_range(0, 1800)) - 900;
            endcase
            send_packet(hdr, kind, 16'(walk));
        end
    endtask

    task automatic test_level_trim();
        send_packet(HDR_SYNC, KIND_ANGLE, 16'sd0);
        send_packet(HDR_SYNC, KIND_ANGLE, 16'sd100);
        send_packet(HDR_SYNC, KIND_ANGLE, -16'sd100);
        send_packet(HDR_SYNC, KIND_ANGLE, 16'sd910);
    endtask

    task automatic test_zone_edges();
        send_packet(HDR_SYNC, KIND_ANGLE, 16'sd1820);
        send_packet(HDR_SYNC, KIND_ANGLE, 16'sd1821);
        send_packet(HDR_SYNC, KIND_ANGLE, -16'sd1821);
        send_packet(HDR_SYNC, KIND_ANGLE, 16'sd4551);
        send_packet(HDR_SYNC, KIND_ANGLE, -16'sd4551);
        send_packet(HDR_SYNC, KIND_ANGLE, 16'sd3000);
        send_packet(HDR_SYNC, KIND_ANGLE, -16'sd3000);
        send_packet(HDR_SYNC, KIND_ANGLE, 16'sh7fff);
        send_packet(HDR_SYNC, KIND_ANGLE, -16'sh8000);
    endtask

    task automatic test_header_filter();
        send_packet(8'h54, KIND_ANGLE, 16'sd1000);
        send_packet(8'haa, KIND_ANGLE, -16'sd5000);
        send_packet(HDR_SYNC, 8'h00, 16'sd12345);
        send_packet(HDR_SYNC, 8'hff, 16'sd0);
    endtask

    task automatic test_gain_extremes();
        wait_results_drained();
        program_gains(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_packet(HDR_SYNC, KIND_ANGLE, 16'sd3000);
        send_packet(HDR_SYNC, KIND_ANGLE, -16'sd3000);
        send_packet(HDR_SYNC, KIND_ANGLE, 16'sd500);
        send_packet(HDR_SYNC, KIND_ANGLE, 16'sd0);
        wait_results_drained();
        program_gains(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send_packet(HDR_SYNC, KIND_ANGLE, 16'sd4000);
        send_packet(HDR_SYNC, KIND_ANGLE, -16'sd4000);
        send_packet(HDR_SYNC, KIND_ANGLE, 16'sd200);
    endtask

    task automatic test_saturation_random();
        wait_results_drained();
        program_gains(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_random_packets(300);
        wait_results_drained();
        program_gains(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_random_packets(300);
        wait_results_drained();
        program_gains(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_random_packets(150);
    endtask

    task automatic test_random_gains();
        wait_results_drained();
        program_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        send_random_packets(400);
        // sender holds off until the block has nothing in flight
        wait_results_drained();
        send_random_packets(400);
    endtask

    task automatic test_rate_term();
        wait_results_drained();
        program_gains(16'($urandom_range(0, 512)), 16'($urandom_range(256, 2048)),
                      16'($urandom_range(0, 1024) - 512), 16'($urandom_range(0, 2560)));
        send_random_packets(400);
    endtask

    always @(posedge aclk) begin
        if (rx_stall_left == 0 && rx_run_left == 0) begin
            case ($urandom_range(0, 3))
                0: begin
                    rx_run_left   = $urandom_range(50, 300);
                    rx_stall_left = 0;
                end
                1: begin
                    rx_run_left   = $urandom_range(1, 4);
                    rx_stall_left = $urandom_range(1, 4);
                end
                2: begin
                    rx_run_left   = $urandom_range(1, 10);
                    rx_stall_left = $urandom_range(10, 40);
                end
                default: begin
                    rx_run_left   = $urandom_range(1, 20);
                    rx_stall_left = $urandom_range(0, 2);
                end
            endcase
        end
        if (rx_stall_left != 0) begin
            rx_stall_left--;
            m_ready <= 1'b0;
        end else begin
            rx_run_left--;
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (servo_results_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transaction: servo %0d drive %0d zone %0d latched %0b",
                             m_servo_compare, m_drive_angle, m_zone, m_trim_latched);
            end else begin
                want = servo_results_q.pop_front();
                if (m_servo_compare !== want.servo || m_drive_angle !== want.drive ||
                    m_zone !== want.zone || m_trim_latched !== want.latched) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $write("mismatch (exp/act): servo %0d/%0d drive %0d/%0d ",
                               want.servo, m_servo_compare, want.drive, m_drive_angle);
                        $display("zone %0d/%0d latched %0b/%0b",
                                 want.zone, m_zone, want.latched, m_trim_latched);
                    end
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        reset_controller_model();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_level_trim();
        test_zone_edges();
        test_header_filter();
        test_gain_extremes();
        test_saturation_random();
        test_random_gains();
        test_rate_term();
        wait_results_drained();
        if (mismatch_count == 0 && servo_results_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
